>>> rtl/stip_pkg.sv
// ----------------------------------------------------------------------------
// stip_pkg
// Shared types, constants and functions of the string to integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stip_pkg;

    // Default character count limit of one string.
    localparam int DEF_MAX_CHARS = 255;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NUMBER_BASE = 2'd0;
    localparam logic [1:0] CFG_SIGNED_MODE = 2'd1;
    localparam logic [1:0] CFG_WIDE_MODE   = 2'd2;

    // Width of the configuration write data (the widest register).
    localparam int CFG_DATA_W = 6;

    // Digit code of a character that is no digit in any base.
    localparam logic [5:0] NO_DIGIT = 6'd63;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic [5:0] number_base;
        logic       signed_mode;
        logic       wide_mode;
    } t_cfg;

    // One classified character as it travels through the queue.
    typedef struct packed {
        logic       is_ws;
        logic       is_minus;
        logic       is_plus;
        logic       is_zero;
        logic       is_x;
        logic [5:0] digit;
        logic       last;
        logic       ignore;
        logic       len_over;
    } t_qitem;

    // Largest magnitude allowed by the mode and the sign.
    function automatic logic [63:0] magnitude_limit(input logic signed_mode,
                                                    input logic wide_mode,
                                                    input logic negative);
        logic [63:0] m;
        if (signed_mode) begin
            m = wide_mode ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
            if (negative) begin
                m = m + 64'd1;
            end
        end else begin
            m = wide_mode ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/stip_front.sv
// ----------------------------------------------------------------------------
// stip_front
// Accepts characters, counts the string length and classifies each one.
// ----------------------------------------------------------------------------
`default_nettype none

module stip_front
    import stip_pkg::*;
#(
    parameter int MAX_CHARS = DEF_MAX_CHARS,
    parameter int PW        = $clog2(MAX_CHARS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_char_code,
    input  wire logic          i_last_char,
    input  wire logic          i_space,
    output logic               o_ready,
    output logic               o_push,
    output t_qitem             o_item,
    output logic [PW-1:0]      o_pos
);

    logic [PW-1:0] r_count;
    logic          r_len_over;
    logic          accept;
    logic          at_limit;

    assign o_ready  = i_space;
    assign accept   = i_valid && i_space;
    assign o_push   = accept;
    assign at_limit = (r_count >= PW'(MAX_CHARS));
    assign o_pos    = r_count + PW'(1);

    // Classify the character.
    always_comb begin
        o_item          = '0;
        o_item.is_ws    = (i_char_code == 8'h20) || (i_char_code == 8'h09) ||
                          (i_char_code == 8'h0A) || (i_char_code == 8'h0D);
        o_item.is_minus = (i_char_code == 8'h2D);
        o_item.is_plus  = (i_char_code == 8'h2B);
        o_item.is_zero  = (i_char_code == 8'h30);
        o_item.is_x     = (i_char_code == 8'h78) || (i_char_code == 8'h58);
        if (i_char_code >= 8'h30 && i_char_code <= 8'h39) begin
            o_item.digit = 6'(i_char_code - 8'h30);
        end else if (i_char_code >= 8'h61 && i_char_code <= 8'h7A) begin
            o_item.digit = 6'(i_char_code - 8'h61 + 8'd10);
        end else if (i_char_code >= 8'h41 && i_char_code <= 8'h5A) begin
            o_item.digit = 6'(i_char_code - 8'h41 + 8'd10);
        end else begin
            o_item.digit = NO_DIGIT;
        end
        o_item.last     = i_last_char;
        o_item.ignore   = r_len_over || at_limit;
        o_item.len_over = r_len_over || at_limit;
    end

    // Length counter, cleared after the last character of a string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_len_over <= 1'b0;
        end else if (accept) begin
            if (i_last_char) begin
                r_count    <= '0;
                r_len_over <= 1'b0;
            end else if (!r_len_over) begin
                if (at_limit) begin
                    r_len_over <= 1'b1;
                end else begin
                    r_count <= o_pos;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/stip_queue.sv
// ----------------------------------------------------------------------------
// stip_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module stip_queue
    import stip_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output logic [DATA_W-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wptr;
    logic [AW-1:0]     r_rptr;
    logic [CW-1:0]     r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_fill == CW'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/stip_back.sv
// ----------------------------------------------------------------------------
// stip_back
// Runs the parse phases, accumulates digits and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module stip_back
    import stip_pkg::*;
#(
    parameter int MAX_CHARS = DEF_MAX_CHARS,
    parameter int PW        = $clog2(MAX_CHARS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cfg          i_cfg,
    input  wire logic          i_empty,
    input  wire t_qitem        i_item,
    input  wire logic [PW-1:0] i_pos,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [63:0]        o_value_bits,
    output logic [7:0]         o_chars_used,
    output logic               o_overflowed,
    output logic               o_length_capped
);

    typedef enum logic [4:0] {
        PH_WS     = 5'b00001,
        PH_START  = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ACC    = 3'b010,
        ST_RESULT = 3'b100
    } t_bstate;

    t_bstate       r_state, n_state;
    t_phase        r_phase, n_phase;
    logic          r_neg, n_neg;
    logic          r_seen, n_seen;
    logic [63:0]   r_acc, n_acc;
    logic [5:0]    r_base, n_base;
    logic [PW-1:0] r_end, n_end;
    logic          r_sat, n_sat;
    logic          r_last, n_last;
    logic          r_len_over, n_len_over;
    logic [PW-1:0] r_pos, n_pos;
    logic [5:0]    r_digit, n_digit;
    logic [69:0]   r_prod, n_prod;
    logic          r_out_valid;
    logic [63:0]   r_out_value, n_out_value;
    logic [7:0]    r_out_used, n_out_used;
    logic          r_out_ovf, n_out_ovf;
    logic          r_out_cap;
    logic          load_out;

    assign o_out_valid     = r_out_valid;
    assign o_value_bits    = r_out_value;
    assign o_chars_used    = r_out_used;
    assign o_overflowed    = r_out_ovf;
    assign o_length_capped = r_out_cap;

    // Phase sequencing, digit accumulation and result forming.
    always_comb begin
        t_phase      ph;
        logic [5:0]  ab;
        logic [5:0]  b;
        logic        cont;
        logic        go_acc;
        logic [69:0] sum;
        logic [63:0] lim;
        logic [63:0] mag;
        logic        ovf;

        n_state     = r_state;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_seen      = r_seen;
        n_acc       = r_acc;
        n_base      = r_base;
        n_end       = r_end;
        n_sat       = r_sat;
        n_last      = r_last;
        n_len_over  = r_len_over;
        n_pos       = r_pos;
        n_digit     = r_digit;
        n_prod      = r_prod;
        n_out_value = r_out_value;
        n_out_used  = r_out_used;
        n_out_ovf   = r_out_ovf;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        ph          = r_phase;
        ab          = r_base;
        b           = i_cfg.number_base;
        cont        = 1'b0;
        go_acc      = 1'b0;
        sum         = r_prod + 70'(r_digit);
        lim         = magnitude_limit(i_cfg.signed_mode, i_cfg.wide_mode, r_neg);
        mag         = r_acc;
        ovf         = r_sat;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop      = 1'b1;
                    n_last     = i_item.last;
                    n_len_over = i_item.len_over;
                    n_pos      = i_pos;
                    n_digit    = i_item.digit;
                    cont       = !i_item.ignore && (r_phase != PH_DONE);
                    // Leading whitespace and the optional sign.
                    if (cont && ph == PH_WS) begin
                        if (i_item.is_ws) begin
                            cont = 1'b0;
                        end else begin
                            ph = PH_START;
                            if (i_item.is_minus) begin
                                n_neg = 1'b1;
                                cont  = 1'b0;
                            end else if (i_item.is_plus) begin
                                cont = 1'b0;
                            end
                        end
                    end
                    // Base selection and the radix prefix.
                    if (cont && ph == PH_START) begin
                        if (b == 6'd1 || b > 6'd36) begin
                            ph   = PH_DONE;
                            cont = 1'b0;
                        end else if ((b == 6'd0 || b == 6'd16) && i_item.is_zero) begin
                            n_seen = 1'b1;
                            n_end  = i_pos;
                            ab     = b;
                            ph     = PH_ZERO;
                            cont   = 1'b0;
                        end else begin
                            ab = (b == 6'd0) ? 6'd10 : b;
                            ph = PH_DIGITS;
                        end
                    end else if (cont && ph == PH_ZERO) begin
                        if (i_item.is_x) begin
                            ab   = 6'd16;
                            ph   = PH_DIGITS;
                            cont = 1'b0;
                        end else begin
                            if (ab == 6'd0) begin
                                ab = 6'd8;
                            end
                            ph = PH_DIGITS;
                        end
                    end
                    // Digit in the active base.
                    if (cont && ph == PH_DIGITS) begin
                        if (i_item.digit >= ab || ab < 6'd2) begin
                            ph = PH_DONE;
                        end else if (!r_sat) begin
                            go_acc = 1'b1;
                        end else begin
                            n_seen = 1'b1;
                            n_end  = i_pos;
                        end
                    end
                    n_phase = ph;
                    n_base  = ab;
                    n_prod  = 70'(r_acc) * 70'(ab);
                    if (go_acc) begin
                        n_state = ST_ACC;
                    end else if (i_item.last) begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_ACC: begin
                // The product plus the digit is checked against the limit.
                if (sum > 70'(lim)) begin
                    n_sat = 1'b1;
                end else begin
                    n_acc = sum[63:0];
                end
                n_seen  = 1'b1;
                n_end   = r_pos;
                n_state = r_last ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    if (ovf || mag > lim) begin
                        mag = lim;
                        ovf = 1'b1;
                    end
                    n_out_value = (i_cfg.signed_mode && r_neg) ? (64'd0 - mag) : mag;
                    if (!r_seen) begin
                        n_out_used = 8'd0;
                    end else if (32'(r_end) > 32'd255) begin
                        n_out_used = 8'hFF;
                    end else begin
                        n_out_used = 8'(r_end);
                    end
                    n_out_ovf = ovf;
                    n_phase   = PH_WS;
                    n_neg     = 1'b0;
                    n_seen    = 1'b0;
                    n_acc     = '0;
                    n_base    = '0;
                    n_end     = '0;
                    n_sat     = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_WS;
            r_neg       <= 1'b0;
            r_seen      <= 1'b0;
            r_acc       <= '0;
            r_base      <= '0;
            r_end       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_seen  <= n_seen;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_end   <= n_end;
            r_sat   <= n_sat;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item holding registers and the result register.
    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_len_over  <= n_len_over;
        r_pos       <= n_pos;
        r_digit     <= n_digit;
        r_prod      <= n_prod;
        r_out_value <= n_out_value;
        r_out_used  <= n_out_used;
        r_out_ovf   <= n_out_ovf;
        if (load_out) begin
            r_out_cap <= r_len_over;
        end
    end

endmodule

`default_nettype wire

>>> rtl/string_to_integer_parser_unit.sv
// ----------------------------------------------------------------------------
// string_to_integer_parser_unit
// Parses a character stream into an integer with base prefix, sign and
// saturation on overflow.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                   | Payload
//  ---------+-----------+-----------------------------+-------------------------
//  input    | in        | i_in_valid / o_in_ready     | i_char_code, i_last_char
//  output   | out       | o_out_valid / i_out_ready   | o_value_bits, o_chars_used,
//           |           |                             | o_overflowed, o_length_capped
//  config   | in        | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// The front takes one character a cycle, while the two-entry queue has room.
// The back pops each character in its idle state; a digit still to be added
// registers the 64 by 6 multiply; the accumulate state then adds the digit and
// checks the limit. After a last character the result state forms the result.
// Reset sets base 10, signed and wide mode, and clears the parse state.
// A stalled result holds the back; the queue then fills and lowers o_in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module string_to_integer_parser_unit
    import stip_pkg::*;
#(
    parameter int MAX_CHARS = DEF_MAX_CHARS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_char_code,
    input  wire logic                  i_last_char,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [63:0]                o_value_bits,
    output logic [7:0]                 o_chars_used,
    output logic                       o_overflowed,
    output logic                       o_length_capped,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW     = $clog2(MAX_CHARS + 1);
    localparam int DATA_W = $bits(t_qitem) + PW;

    logic [5:0]        r_number_base;
    logic              r_signed_mode;
    logic              r_wide_mode;
    t_cfg              cfg;
    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    t_qitem            f_item;
    logic [PW-1:0]     f_pos;
    logic [DATA_W-1:0] q_rdata;
    t_qitem            b_item;
    logic [PW-1:0]     b_pos;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= 6'd10;
            r_signed_mode <= 1'b1;
            r_wide_mode   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUMBER_BASE: r_number_base <= i_cfg_data[5:0];
                CFG_SIGNED_MODE: r_signed_mode <= i_cfg_data[0];
                CFG_WIDE_MODE:   r_wide_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.number_base = r_number_base;
    assign cfg.signed_mode = r_signed_mode;
    assign cfg.wide_mode   = r_wide_mode;

    // Character intake and classification.
    stip_front #(
        .MAX_CHARS (MAX_CHARS),
        .PW        (PW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_space     (!q_full),
        .o_ready     (o_in_ready),
        .o_push      (q_push),
        .o_item      (f_item),
        .o_pos       (f_pos)
    );

    // Queue between the two halves.
    stip_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_item, f_pos}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    assign b_item = t_qitem'(q_rdata[DATA_W-1:PW]);
    assign b_pos  = q_rdata[PW-1:0];

    // Parse execution and result register.
    stip_back #(
        .MAX_CHARS (MAX_CHARS),
        .PW        (PW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_empty         (q_empty),
        .i_item          (b_item),
        .i_pos           (b_pos),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_value_bits    (o_value_bits),
        .o_chars_used    (o_chars_used),
        .o_overflowed    (o_overflowed),
        .o_length_capped (o_length_capped)
    );

endmodule

`default_nettype wire

>>> rtl/stip_checker.sv
// ----------------------------------------------------------------------------
// stip_checker
// Port level checks of the string to integer parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stip_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_value_bits,
    input wire logic [7:0]  o_chars_used,
    input wire logic        o_overflowed,
    input wire logic        o_length_capped
);

    // A stalled result request keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value_bits) &&
        $stable(o_chars_used) && $stable(o_overflowed) && $stable(o_length_capped))
        else $error("result changed while stalled");

    // Without any accepted digit the value is zero and cannot overflow.
    a_no_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_chars_used == 8'd0) |-> (o_value_bits == 64'd0) && !o_overflowed)
        else $error("nonzero value without digits");

    // Saturation needs at least one consumed digit.
    a_ovf_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflowed |-> (o_chars_used != 8'd0))
        else $error("overflow without consumed characters");

    // Reset drops any pending result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind string_to_integer_parser_unit stip_checker u_stip_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_value_bits    (o_value_bits),
    .o_chars_used    (o_chars_used),
    .o_overflowed    (o_overflowed),
    .o_length_capped (o_length_capped)
);

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// string_to_integer_parser_unit testbench
// Streams character strings into the parser under a range of base, sign and
// width settings. A scoreboard predicts every parse result and compares each
// returned result field by field, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench
    import stip_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF      = 4;
    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned MAX_GAP       = 18;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned HOLD_AFTER    = 60;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned MAX_RADIX     = 36;
    localparam int unsigned PHASE_ITEMS   = 80;
    localparam int unsigned FIXED_PHASES  = 10;
    localparam int unsigned ALL_PHASES    = 12;

    // Character codes that steer the parse.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = "+";
    localparam logic [7:0] CH_MINUS   = "-";
    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_X = "X";
    localparam logic [7:0] CH_UPPER_Z = "Z";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_X = "x";
    localparam logic [7:0] CH_LOWER_Z = "z";

    // Settings of the fixed phases; the last phases draw their own.
    localparam logic [5:0] PLAN_BASE [FIXED_PHASES] = '{10, 0, 16, 2, 36, 8, 0, 1, 37, 63};
    localparam logic PLAN_SIGNED [FIXED_PHASES] = '{1, 1, 0, 1, 0, 1, 0, 1, 1, 0};
    localparam logic PLAN_WIDE   [FIXED_PHASES] = '{1, 1, 1, 0, 0, 1, 0, 1, 0, 1};

    typedef enum logic [4:0] {
        SCAN_BLANKS  = 5'b00001,
        SCAN_SIGN    = 5'b00010,
        SCAN_ZERO    = 5'b00100,
        SCAN_DIGITS  = 5'b01000,
        SCAN_STOPPED = 5'b10000
    } t_scan_phase;

    typedef struct {
        logic [63:0] value;
        logic [7:0]  used;
        logic        ovf;
        logic        capped;
    } t_parse_result;

    // Predicts parse results from accepted requests and checks returned ones.
    class integer_parse_checker;
        t_cfg          settings;
        t_scan_phase   phase;
        logic          negative;
        logic          got_digit;
        logic [63:0]   magnitude;
        logic [5:0]    radix;
        int unsigned   seen_chars;
        int unsigned   digits_end;
        logic          pinned;
        logic          too_long;
        t_parse_result awaited_values[$];
        int unsigned   fail_count;

        function new();
            settings.number_base = 6'd10;
            settings.signed_mode = 1'b1;
            settings.wide_mode   = 1'b1;
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            phase      = SCAN_BLANKS;
            negative   = 1'b0;
            got_digit  = 1'b0;
            magnitude  = '0;
            radix      = '0;
            seen_chars = 0;
            digits_end = 0;
            pinned     = 1'b0;
            too_long   = 1'b0;
        endfunction

        function void set_register(logic [1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_NUMBER_BASE: settings.number_base = data;
                CFG_SIGNED_MODE: settings.signed_mode = data[0];
                CFG_WIDE_MODE:   settings.wide_mode   = data[0];
                default: ;
            endcase
        endfunction

        // Largest magnitude for the current mode; a negative value reaches one more.
        function logic [63:0] ceiling();
            logic [63:0] top;
            if (settings.signed_mode) begin
                top = settings.wide_mode ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
                if (negative) begin
                    top = top + 64'd1;
                end
            end else begin
                top = settings.wide_mode ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
            end
            return top;
        endfunction

        function logic [5:0] digit_of(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) begin
                return 6'(c - CH_ZERO);
            end
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                return 6'(c - CH_LOWER_A + 8'd10);
            end
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                return 6'(c - CH_UPPER_A + 8'd10);
            end
            return NO_DIGIT;
        endfunction

        // Advances the parse by one character at position pos.
        function void absorb_char(logic [7:0] c, int unsigned pos);
            logic [5:0]  b;
            logic [5:0]  d;
            logic [63:0] top;
            if (phase == SCAN_BLANKS) begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
                    return;
                end
                phase = SCAN_SIGN;
                if (c == CH_MINUS) begin
                    negative = 1'b1;
                    return;
                end
                if (c == CH_PLUS) begin
                    return;
                end
            end
            // The base is fixed by the first character after blanks and sign.
            if (phase == SCAN_SIGN) begin
                b = settings.number_base;
                if (b == 6'd1 || b > MAX_RADIX) begin
                    phase = SCAN_STOPPED;
                    return;
                end
                if ((b == 6'd0 || b == 6'd16) && c == CH_ZERO) begin
                    got_digit  = 1'b1;
                    digits_end = pos;
                    radix      = b;
                    phase      = SCAN_ZERO;
                    return;
                end
                radix = (b == 6'd0) ? 6'd10 : b;
                phase = SCAN_DIGITS;
            end else if (phase == SCAN_ZERO) begin
                if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                    radix = 6'd16;
                    phase = SCAN_DIGITS;
                    return;
                end
                if (radix == 6'd0) begin
                    radix = 6'd8;
                end
                phase = SCAN_DIGITS;
            end
            if (phase == SCAN_DIGITS) begin
                d = digit_of(c);
                if (d >= radix || radix < 6'd2) begin
                    phase = SCAN_STOPPED;
                    return;
                end
                // Once the limit is hit the value stays pinned there.
                if (!pinned) begin
                    top = ceiling();
                    if (magnitude > (top - 64'(d)) / 64'(radix)) begin
                        pinned = 1'b1;
                    end else begin
                        magnitude = magnitude * 64'(radix) + 64'(d);
                    end
                end
                got_digit  = 1'b1;
                digits_end = pos;
            end
        endfunction

        // Notes one accepted request; the last character of a string yields a result.
        function void note_request(logic [7:0] c, logic last);
            t_parse_result r;
            logic [63:0]   top;
            logic [63:0]   mag;
            logic          ovf;
            if (!too_long) begin
                if (seen_chars >= DEF_MAX_CHARS) begin
                    too_long = 1'b1;
                end else begin
                    seen_chars++;
                    if (phase != SCAN_STOPPED) begin
                        absorb_char(c, seen_chars);
                    end
                end
            end
            if (!last) begin
                return;
            end
            top = ceiling();
            mag = magnitude;
            ovf = pinned;
            if (ovf || mag > top) begin
                mag = top;
                ovf = 1'b1;
            end
            r.value  = (settings.signed_mode && negative) ? 64'd0 - mag : mag;
            r.used   = got_digit ? ((digits_end > 255) ? 8'd255 : 8'(digits_end)) : 8'd0;
            r.ovf    = ovf;
            r.capped = too_long;
            awaited_values.push_back(r);
            restart();
        endfunction

        function void check_result(logic [63:0] value, logic [7:0] used, logic ovf,
                                   logic capped);
            t_parse_result exp;
            if (awaited_values.size() == 0) begin
                $error("result with none awaited: value_bits %h", value);
                fail_count++;
                return;
            end
            exp = awaited_values.pop_front();
            if (exp.value !== value) begin
                $error("value_bits mismatch: expected %h, actual %h", exp.value, value);
                fail_count++;
            end
            if (exp.used !== used) begin
                $error("chars_used mismatch: expected %0d, actual %0d", exp.used, used);
                fail_count++;
            end
            if (exp.ovf !== ovf) begin
                $error("overflowed mismatch: expected %b, actual %b", exp.ovf, ovf);
                fail_count++;
            end
            if (exp.capped !== capped) begin
                $error("length_capped mismatch: expected %b, actual %b", exp.capped, capped);
                fail_count++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_char_code;
    logic                  i_last_char;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [63:0]           o_value_bits;
    logic [7:0]            o_chars_used;
    logic                  o_overflowed;
    logic                  o_length_capped;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    integer_parse_checker tracker;
    logic [7:0]           text[$];
    bit                   tx_burst;
    bit                   rx_burst;

    string_to_integer_parser_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_code     (i_char_code),
        .i_last_char     (i_last_char),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_value_bits    (o_value_bits),
        .o_chars_used    (o_chars_used),
        .o_overflowed    (o_overflowed),
        .o_length_capped (o_length_capped),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Draws a wait; now and then switches into or out of a stretch with no waits.
    function automatic int unsigned pick_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(int unsigned v);
        if (v < 10) begin
            return CH_ZERO + 8'(v);
        end
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 10);
    endfunction

    function automatic void push_digits(int unsigned n, int unsigned radix);
        repeat (n) text.push_back(digit_char($urandom_range(0, radix - 1)));
    endfunction

    function automatic void push_string(string s);
        for (int k = 0; k < s.len(); k++) begin
            text.push_back(s[k]);
        end
    endfunction

    // Builds one random string for the given settings into the text buffer.
    function automatic void compose_text(logic [5:0] base, logic sgn, logic wide,
                                         bit long_one);
        int unsigned radix;
        int unsigned style;
        int unsigned at;
        logic [63:0] top;
        bit          neg;
        radix = (base >= 2 && base <= MAX_RADIX) ? base : 10;
        style = $urandom_range(0, 11);
        if (long_one) begin
            // Runs past the length cap; digits land around the cap boundary.
            repeat ($urandom_range(240, 262)) text.push_back(blank_char());
            push_digits($urandom_range(1, 20), radix);
        end else if (style == 0) begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end else if (style == 1) begin
            // A value at, just under or just past the limit of the current mode.
            neg = sgn && $urandom_range(0, 1);
            if (sgn) begin
                top = wide ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h0000_0000_7FFF_FFFF;
            end else begin
                top = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
            end
            if (neg) begin
                top = top + 64'd1;
                text.push_back(CH_MINUS);
            end else if ($urandom_range(0, 1)) begin
                text.push_back(CH_PLUS);
            end
            if (base == 6'd16 && $urandom_range(0, 1)) begin
                text.push_back(CH_ZERO);
                text.push_back(CH_LOWER_X);
            end
            top = top - 64'($urandom_range(0, 1));
            at = text.size();
            do begin
                text.insert(at, digit_char(32'(top % 64'(radix))));
                top = top / 64'(radix);
            end while (top != 0);
            if ($urandom_range(0, 2) == 0) begin
                push_digits(1, radix);
            end
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) text.push_back(blank_char());
            end
            case ($urandom_range(0, 3))
                0: text.push_back(CH_MINUS);
                1: text.push_back(CH_PLUS);
                default: ;
            endcase
            if ((base == 6'd0 || base == 6'd16) && $urandom_range(0, 2) == 0) begin
                text.push_back(CH_ZERO);
                text.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
                radix = 16;
            end else if (base == 6'd0 && $urandom_range(0, 2) == 0) begin
                text.push_back(CH_ZERO);
                radix = 8;
            end
            push_digits(($urandom_range(0, 7) == 0) ? $urandom_range(15, 70)
                                                    : $urandom_range(0, 8), radix);
            // Optional tail: a stray character, or a terminator with junk after it.
            case ($urandom_range(0, 5))
                0: text.push_back(8'($urandom_range(0, 255)));
                1: begin
                    text.push_back(CH_NUL);
                    repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
        end
        if (text.size() == 0) begin
            text.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Offers one request and waits for it to be taken. Valid stays high into the
    // next request when no wait follows and more requests come.
    task automatic send_char(input logic [7:0] c, input logic last, input bit more);
        int unsigned gap;
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_request(c, last);
        @(negedge i_clk);
        gap = pick_gap(tx_burst);
        if (!more || gap > 0) begin
            i_in_valid <= 1'b0;
        end
        if (more) begin
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_text(input bit closes_phase);
        int unsigned n;
        n = text.size();
        for (int unsigned k = 0; k < n; k++) begin
            send_char(text[k], k == n - 1, !(closes_phase && k == n - 1));
        end
        text.delete();
    endtask

    // Waits until every awaited result is back and the block has drained.
    task automatic wait_idle();
        while (tracker.awaited_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [5:0] base, input logic sgn,
                                  input logic wide);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_NUMBER_BASE;
        i_cfg_data  <= base;
        tracker.set_register(CFG_NUMBER_BASE, base);
        @(negedge i_clk);
        i_cfg_index <= CFG_SIGNED_MODE;
        i_cfg_data  <= CFG_DATA_W'(sgn);
        tracker.set_register(CFG_SIGNED_MODE, CFG_DATA_W'(sgn));
        @(negedge i_clk);
        i_cfg_index <= CFG_WIDE_MODE;
        i_cfg_data  <= CFG_DATA_W'(wide);
        tracker.set_register(CFG_WIDE_MODE, CFG_DATA_W'(wide));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off so the input backs up.
    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = (taken == HOLD_AFTER) ? HOLD_CYCLES : pick_gap(rx_burst);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            tracker.check_result(o_value_bits, o_chars_used, o_overflowed, o_length_capped);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("string_to_integer_parser_unit test failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase_sent;
        bit          closes;
        logic [5:0]  base;
        logic        sgn;
        logic        wide;
        tracker     = new();
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_char_code <= CH_NUL;
        i_last_char <= 1'b0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_NUMBER_BASE;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed strings under the reset settings: all blank kinds with a
        // minus, a lone sign, a terminator followed by a digit, a top code.
        text.push_back(CH_SPACE);
        text.push_back(CH_TAB);
        text.push_back(CH_LF);
        text.push_back(CH_CR);
        push_string("-42");
        send_text(1'b0);
        push_string("+");
        send_text(1'b0);
        push_string("7");
        text.push_back(CH_NUL);
        push_string("9");
        send_text(1'b0);
        text.push_back(8'hFF);
        send_text(1'b1);

        // Hex prefix cases: prefix with no hex digit, mixed case, prefix alone.
        wait_idle();
        write_settings(6'd16, 1'b1, 1'b1);
        push_string("0xg");
        send_text(1'b0);
        push_string("-0XfF");
        send_text(1'b0);
        push_string("0x");
        send_text(1'b1);

        // Random phases, each under its own settings.
        for (int unsigned p = 0; p < ALL_PHASES; p++) begin
            if (p < FIXED_PHASES) begin
                base = PLAN_BASE[p];
                sgn  = PLAN_SIGNED[p];
                wide = PLAN_WIDE[p];
            end else begin
                base = 6'($urandom_range(0, 40));
                sgn  = 1'($urandom_range(0, 1));
                wide = 1'($urandom_range(0, 1));
            end
            wait_idle();
            write_settings(base, sgn, wide);
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                compose_text(base, sgn, wide, (p == 2 || p == 6) && phase_sent == 0);
                phase_sent += text.size();
                closes = phase_sent >= PHASE_ITEMS;
                send_text(closes);
            end
        end

        wait_idle();
        if (tracker.fail_count == 0) begin
            $display("string_to_integer_parser_unit test passed");
        end else begin
            $display("string_to_integer_parser_unit test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/stip_pkg.sv
rtl/stip_front.sv
rtl/stip_queue.sv
rtl/stip_back.sv
rtl/string_to_integer_parser_unit.sv
rtl/stip_checker.sv
verif/testbench.sv
